### hdl/ssq_pkg.sv
package ssq_pkg;

  localparam int TAG_W = 8;
  localparam int POS_W = 48;
  localparam int LEN_W = 16;
  localparam int ACT_W = 2;
  localparam int STS_W = 3;

  localparam logic [ACT_W-1:0] ACT_ADD      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DISPATCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 2'd2;

  typedef enum logic [STS_W-1:0] {
    STS_ADDED      = 3'd0,
    STS_DISPATCHED = 3'd1,
    STS_EMPTY      = 3'd2,
    STS_FULL       = 3'd3,
    STS_REMOVED    = 3'd4,
    STS_NOT_FOUND  = 3'd5
  } status_t;

endpackage

### hdl/ssq_req_if.sv
interface ssq_req_if;
  import ssq_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [TAG_W-1:0] request_tag;
  logic [POS_W-1:0] request_position;
  logic [LEN_W-1:0] request_length;

  modport source (output valid, action, request_tag, request_position, request_length,
                  input ready);
  modport sink   (input valid, action, request_tag, request_position, request_length,
                  output ready);
endinterface

### hdl/ssq_rsp_if.sv
interface ssq_rsp_if;
  import ssq_pkg::*;

  logic             valid;
  logic             ready;
  status_t          status;
  logic [TAG_W-1:0] out_tag;
  logic [POS_W-1:0] out_position;
  logic [LEN_W-1:0] out_length;

  modport source (output valid, status, out_tag, out_position, out_length, input ready);
  modport sink   (input valid, status, out_tag, out_position, out_length, output ready);
endinterface

### hdl/ssq_store.sv
// Request queue storage: one write port, one registered read port.
module ssq_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int PW    = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [PW-1:0]            wpos,
  input  logic [ssq_pkg::LEN_W-1:0] wlen,
  input  logic [ssq_pkg::TAG_W-1:0] wtag,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [PW-1:0]            rpos,
  output logic [ssq_pkg::LEN_W-1:0] rlen,
  output logic [ssq_pkg::TAG_W-1:0] rtag
);
  import ssq_pkg::*;

  logic [PW-1:0]    pos_mem [DEPTH];
  logic [LEN_W-1:0] len_mem [DEPTH];
  logic [TAG_W-1:0] tag_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      pos_mem[waddr] <= wpos;
      len_mem[waddr] <= wlen;
      tag_mem[waddr] <= wtag;
    end
    if (re) begin
      rpos <= pos_mem[raddr];
      rlen <= len_mem[raddr];
      rtag <= tag_mem[raddr];
    end
  end

endmodule

### hdl/ssq_seek_unit.sv
// Distance / compare unit: keeps the nearest entry seen so far.
module ssq_seek_unit #(
  parameter int AW = 5,
  parameter int PW = 48,
  parameter int HW = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clr,
  input  logic                      vld,
  input  logic [HW-1:0]             head,
  input  logic [PW-1:0]             pos,
  input  logic [ssq_pkg::LEN_W-1:0] len,
  input  logic [ssq_pkg::TAG_W-1:0] tag,
  input  logic [AW-1:0]             idx,
  output logic [PW-1:0]             best_pos,
  output logic [ssq_pkg::LEN_W-1:0] best_len,
  output logic [ssq_pkg::TAG_W-1:0] best_tag,
  output logic [AW-1:0]             best_idx
);
  import ssq_pkg::*;

  logic          found;
  logic [HW-1:0] best_dist;
  logic [HW-1:0] pos_ext;
  logic [HW-1:0] span;
  logic          take;

  assign pos_ext = HW'(pos);
  assign span    = (head >= pos_ext) ? head - pos_ext : pos_ext - head;
  // strict compare: ties keep the earlier arrival
  assign take    = vld && (!found || span < best_dist);

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
    if (take) begin
      best_dist <= span;
      best_pos  <= pos;
      best_len  <= len;
      best_tag  <= tag;
      best_idx  <= idx;
    end
  end

endmodule

### hdl/sstf_request_scheduler.sv
// SSTF request scheduler for a queue of N entries. Add answers without a scan; dispatch
// and remove scan the queue (one memory read per cycle during the scan, then one read
// and one write per cycle closing the gap).
// One transaction at a time; ready again the cycle after the response is loaded, later
// while it is held off. Synchronous active-high reset empties the queue, head to zero;
// storage not cleared.
module sstf_request_scheduler #(
  parameter int QUEUE_DEPTH = 32,
  parameter int SECTOR_BITS = 48
) (
  input logic        clk,
  input logic        rst,
  ssq_req_if.sink    req,
  ssq_rsp_if.source  rsp
);
  import ssq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int IW = $clog2(QUEUE_DEPTH + 1);
  // stored positions: the input field, cut to the sector width
  localparam int PW = (SECTOR_BITS < POS_W) ? SECTOR_BITS : POS_W;
  localparam int HW = SECTOR_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SHIFT, ST_REPORT} state_t;

  state_t           state;
  logic [ACT_W-1:0] act;
  logic [TAG_W-1:0] tag_q;
  logic [IW-1:0]    occ;      // queued entries
  logic [HW-1:0]    head;     // head sector
  logic [IW-1:0]    idx;      // next read address
  logic             rd_vld;   // read data valid this cycle
  logic [AW-1:0]    rd_addr;  // address of that read data

  status_t          res_status;
  logic [TAG_W-1:0] res_tag;
  logic [POS_W-1:0] res_pos;
  logic [LEN_W-1:0] res_len;

  logic             rsp_valid;
  status_t          rsp_status;
  logic [TAG_W-1:0] rsp_tag;
  logic [POS_W-1:0] rsp_pos;
  logic [LEN_W-1:0] rsp_len;

  // memory ports
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [PW-1:0]    mem_wpos;
  logic [LEN_W-1:0] mem_wlen;
  logic [TAG_W-1:0] mem_wtag;
  logic             mem_re;
  logic [PW-1:0]    rd_pos;
  logic [LEN_W-1:0] rd_len;
  logic [TAG_W-1:0] rd_tag;

  // seek unit
  logic             seek_vld;
  logic [PW-1:0]    best_pos;
  logic [LEN_W-1:0] best_len;
  logic [TAG_W-1:0] best_tag;
  logic [AW-1:0]    best_idx;

  logic accept, full, add_wr, shift_wr, tag_hit, scan_done, shift_done;

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign full       = (occ == IW'(QUEUE_DEPTH));

  assign mem_re     = (state == ST_SCAN || state == ST_SHIFT) && (idx < occ);
  assign add_wr     = accept && (req.action == ACT_ADD) && !full;
  assign shift_wr   = (state == ST_SHIFT) && rd_vld;   // entry j+1 moves down to j
  assign mem_we     = add_wr || shift_wr;
  assign mem_waddr  = shift_wr ? rd_addr - AW'(1) : occ[AW-1:0];
  assign mem_wpos   = shift_wr ? rd_pos : req.request_position[PW-1:0];
  assign mem_wlen   = shift_wr ? rd_len : req.request_length;
  assign mem_wtag   = shift_wr ? rd_tag : req.request_tag;

  assign seek_vld   = (state == ST_SCAN) && rd_vld && (act == ACT_DISPATCH);
  assign tag_hit    = (state == ST_SCAN) && rd_vld && (act == ACT_REMOVE) && (rd_tag == tag_q);
  assign scan_done  = (state == ST_SCAN) && (idx >= occ) && !rd_vld;
  assign shift_done = (state == ST_SHIFT) && (idx >= occ) && !rd_vld;

  ssq_store #(.DEPTH(QUEUE_DEPTH), .AW(AW), .PW(PW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wpos  (mem_wpos),
    .wlen  (mem_wlen),
    .wtag  (mem_wtag),
    .re    (mem_re),
    .raddr (idx[AW-1:0]),
    .rpos  (rd_pos),
    .rlen  (rd_len),
    .rtag  (rd_tag)
  );

  ssq_seek_unit #(.AW(AW), .PW(PW), .HW(HW)) u_seek (
    .clk      (clk),
    .rst      (rst),
    .clr      (accept),
    .vld      (seek_vld),
    .head     (head),
    .pos      (rd_pos),
    .len      (rd_len),
    .tag      (rd_tag),
    .idx      (rd_addr),
    .best_pos (best_pos),
    .best_len (best_len),
    .best_tag (best_tag),
    .best_idx (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      head      <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= mem_re;
      if (mem_re) begin
        rd_addr <= idx[AW-1:0];
        idx     <= idx + IW'(1);
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            act     <= req.action;
            tag_q   <= req.request_tag;
            idx     <= '0;
            res_tag <= '0;
            res_pos <= '0;
            res_len <= '0;
            case (req.action)
              ACT_ADD: begin
                res_status <= full ? STS_FULL : STS_ADDED;
                if (!full) begin
                  occ <= occ + IW'(1);
                end
                state <= ST_REPORT;
              end
              ACT_DISPATCH: begin
                res_status <= STS_EMPTY;
                state      <= (occ == '0) ? ST_REPORT : ST_SCAN;
              end
              ACT_REMOVE: begin
                res_status <= STS_NOT_FOUND;
                state      <= (occ == '0) ? ST_REPORT : ST_SCAN;
              end
              default: begin
                state <= ST_IDLE;   // unused action: no transaction out
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (tag_hit) begin
            // oldest match: drop in-flight read, close the gap from here
            rd_vld     <= 1'b0;
            idx        <= IW'(rd_addr) + IW'(1);
            res_status <= STS_REMOVED;
            state      <= ST_SHIFT;
          end else if (scan_done) begin
            if (act == ACT_DISPATCH) begin
              res_status <= STS_DISPATCHED;
              res_tag    <= best_tag;
              res_pos    <= POS_W'(best_pos);
              res_len    <= best_len;
              head       <= HW'(best_pos) + HW'(best_len);
              idx        <= IW'(best_idx) + IW'(1);
              state      <= ST_SHIFT;
            end else begin
              state <= ST_REPORT;
            end
          end
        end
        ST_SHIFT: begin
          if (shift_done) begin
            occ   <= occ - IW'(1);
            state <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_tag    <= res_tag;
            rsp_pos    <= res_pos;
            rsp_len    <= res_len;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.out_tag      = rsp_tag;
  assign rsp.out_position = rsp_pos;
  assign rsp.out_length   = rsp_len;

endmodule
